// ===== hdl/vsrt_pkg.sv =====
// vsrt_pkg: shared widths, register codes, reset values and saturation helper
// for the vertex scale / rotate / translate pipeline. No dependencies.
`timescale 1ns / 1ps

package vsrt_pkg;

	// field widths
	localparam int COORD_W    = 32;
	localparam int QWORD_W    = 16;
	localparam int QFRAC      = 14;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int SAT_IN_W   = 64;

	// default fraction bits of coordinates, scales and offsets
	localparam int COORD_FRAC_DEFAULT = 16;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [QWORD_W-1:0] qword_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X  = 3'd0,
		REG_SCALE_Y  = 3'd1,
		REG_SCALE_Z  = 3'd2,
		REG_ROTATION = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6
	} cfg_reg_t;

	// reset values: unit scale, quaternion w = 0.25 and zero vector part
	localparam coord_t           SCALE_RESET = 32'sd65536;
	localparam logic [CFG_W-1:0] ROT_RESET   = 64'h1000_0000_0000_0000;

	localparam logic signed [SAT_IN_W-1:0] COORD_MAX = 64'sd2147483647;
	localparam logic signed [SAT_IN_W-1:0] COORD_MIN = -COORD_MAX - 64'sd1;

	// clamp a wide signed value into the coordinate range
	function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] c;
		begin
			if (v > COORD_MAX)
				c = COORD_MAX;
			else if (v < COORD_MIN)
				c = COORD_MIN;
			else
				c = v;
			sat_coord = c[COORD_W-1:0];
		end
	endfunction

endpackage

// ===== hdl/vertex_scale_rotate_translate.sv =====
// vertex_scale_rotate_translate: seven-stage pipeline that scales, rotates by a
// quaternion and offsets one vertex per item. Depends on vsrt_pkg.
`timescale 1ns / 1ps

// One vertex enters per clock while in_stall is low, and its world-space
// position leaves through the seven register stages (scale multiply,
// round/saturate, cross product multiply, round, second cross product multiply,
// accumulate, round/offset/saturate). Each stage moves on
// when the one after it is empty or moving, so bubbles close up and in_stall
// rises only once all seven stages hold items and out_stall is high. The
// quaternion is used as written, without normalization, and the result is
// saturated to the signed 32-bit range. Configuration registers may be
// written only while no item is in flight; there is no read-back and writes
// to index seven are dropped.
module vertex_scale_rotate_translate
	import vsrt_pkg::*;
#(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// vertex in
	input  logic                 in_valid,
	output logic                 in_stall,
	input  coord_t               in_x,
	input  coord_t               in_y,
	input  coord_t               in_z,
	// vertex out
	output logic                 out_valid,
	input  logic                 out_stall,
	output coord_t               out_x,
	output coord_t               out_y,
	output coord_t               out_z,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PW  = 2 * COORD_W;        // scale product
	localparam int XW  = QWORD_W + COORD_W;  // first cross product term
	localparam int CDW = XW + 1;             // first cross product difference
	localparam int C1W = 36;                 // rounded first cross product
	localparam int DW  = QWORD_W + C1W;      // second cross product term
	localparam int AW  = 56;                 // accumulator

	localparam logic signed [PW:0]    P_HALF = (PW + 1)'(65'd1 << (COORD_FRAC_BITS - 1));
	localparam logic signed [CDW-1:0] C_HALF = CDW'(64'd1 << (QFRAC - 1));
	localparam logic signed [AW-1:0]  A_HALF = AW'(64'd1 << (QFRAC - 1));

	// cyclic neighbors for the cross product
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	// configuration registers
	coord_t           scale_q [3];
	coord_t           offset_q [3];
	logic [CFG_W-1:0] rot_q;
	qword_t           qw;
	qword_t           qv [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q[0]  <= SCALE_RESET;
			scale_q[1]  <= SCALE_RESET;
			scale_q[2]  <= SCALE_RESET;
			rot_q       <= ROT_RESET;
			offset_q[0] <= '0;
			offset_q[1] <= '0;
			offset_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE_X:  scale_q[0]  <= cfg_data[COORD_W-1:0];
				REG_SCALE_Y:  scale_q[1]  <= cfg_data[COORD_W-1:0];
				REG_SCALE_Z:  scale_q[2]  <= cfg_data[COORD_W-1:0];
				REG_ROTATION: rot_q       <= cfg_data;
				REG_OFFSET_X: offset_q[0] <= cfg_data[COORD_W-1:0];
				REG_OFFSET_Y: offset_q[1] <= cfg_data[COORD_W-1:0];
				REG_OFFSET_Z: offset_q[2] <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// quaternion words, w on top
	assign qw    = rot_q[63:48];
	assign qv[0] = rot_q[47:32];
	assign qv[1] = rot_q[31:16];
	assign qv[2] = rot_q[15:0];

	// stage valids and flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7    = !valid_s7 || !out_stall;
	assign en_s6    = !valid_s6 || en_s7;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
		end
	end

	// pipeline payload
	logic signed [PW-1:0]  prod_s1 [3];
	coord_t                scaled_s2 [3];
	coord_t                scaled_s3 [3];
	coord_t                scaled_s4 [3];
	coord_t                scaled_s5 [3];
	logic signed [XW-1:0]  xa_s3 [3];
	logic signed [XW-1:0]  xb_s3 [3];
	logic signed [C1W-1:0] c1_s4 [3];
	logic signed [DW-1:0]  da_s5 [3];
	logic signed [DW-1:0]  db_s5 [3];
	logic signed [DW-1:0]  wc_s5 [3];
	logic signed [AW-1:0]  acc_s6 [3];
	coord_t                res_s7 [3];

	// combinational stage logic
	coord_t                in_v [3];
	logic signed [PW:0]    prod_rnd [3];
	logic signed [PW:0]    prod_sh [3];
	coord_t                scaled_w [3];
	logic signed [XW-1:0]  xa_w [3];
	logic signed [XW-1:0]  xb_w [3];
	logic signed [CDW-1:0] cdiff [3];
	logic signed [CDW-1:0] csh [3];
	logic signed [C1W-1:0] c1_w [3];
	logic signed [DW-1:0]  da_w [3];
	logic signed [DW-1:0]  db_w [3];
	logic signed [DW-1:0]  wc_w [3];
	logic signed [AW-1:0]  s_ext [3];
	logic signed [AW-1:0]  rot_sum [3];
	logic signed [AW-1:0]  acc_w [3];
	logic signed [AW-1:0]  r_w [3];
	logic signed [SAT_IN_W-1:0] pos_w [3];
	coord_t                res_w [3];

	assign in_v[0] = in_x;
	assign in_v[1] = in_y;
	assign in_v[2] = in_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// stage 2: round scale product, saturate
			prod_rnd[i] = (PW + 1)'(prod_s1[i]) + P_HALF;
			prod_sh[i]  = prod_rnd[i] >>> COORD_FRAC_BITS;
			scaled_w[i] = sat_coord(prod_sh[i][SAT_IN_W-1:0]);
			// stage 3: first cross product terms
			xa_w[i] = XW'(qv[NXT[i]]) * XW'(scaled_s2[PRV[i]]);
			xb_w[i] = XW'(qv[PRV[i]]) * XW'(scaled_s2[NXT[i]]);
			// stage 4: difference, round to coordinate units
			cdiff[i] = CDW'(xa_s3[i]) - CDW'(xb_s3[i]);
			csh[i]   = (cdiff[i] + C_HALF) >>> QFRAC;
			c1_w[i]  = csh[i][C1W-1:0];
			// stage 5: second cross product and w terms
			da_w[i] = DW'(qv[NXT[i]]) * DW'(c1_s4[PRV[i]]);
			db_w[i] = DW'(qv[PRV[i]]) * DW'(c1_s4[NXT[i]]);
			wc_w[i] = DW'(qw) * DW'(c1_s4[i]);
			// stage 6: accumulate
			s_ext[i]   = AW'(scaled_s5[i]);
			rot_sum[i] = AW'(wc_s5[i]) + AW'(da_s5[i]) - AW'(db_s5[i]);
			acc_w[i]   = (s_ext[i] <<< QFRAC) + (rot_sum[i] <<< 1);
			// stage 7: round, add offset, saturate
			r_w[i]   = (acc_s6[i] + A_HALF) >>> QFRAC;
			pos_w[i] = SAT_IN_W'(r_w[i]) + SAT_IN_W'(offset_q[i]);
			res_w[i] = sat_coord(pos_w[i]);
		end
	end

	// payload registers load when their stage advances with an item
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (en_s1 && in_valid)
				prod_s1[i] <= PW'(in_v[i]) * PW'(scale_q[i]);
			if (en_s2 && valid_s1)
				scaled_s2[i] <= scaled_w[i];
			if (en_s3 && valid_s2) begin
				xa_s3[i]     <= xa_w[i];
				xb_s3[i]     <= xb_w[i];
				scaled_s3[i] <= scaled_s2[i];
			end
			if (en_s4 && valid_s3) begin
				c1_s4[i]     <= c1_w[i];
				scaled_s4[i] <= scaled_s3[i];
			end
			if (en_s5 && valid_s4) begin
				da_s5[i]     <= da_w[i];
				db_s5[i]     <= db_w[i];
				wc_s5[i]     <= wc_w[i];
				scaled_s5[i] <= scaled_s4[i];
			end
			if (en_s6 && valid_s5)
				acc_s6[i] <= acc_w[i];
			if (en_s7 && valid_s6)
				res_s7[i] <= res_w[i];
		end
	end

	assign out_valid = valid_s7;
	assign out_x     = res_s7[0];
	assign out_y     = res_s7[1];
	assign out_z     = res_s7[2];

	// an empty first stage always takes an item
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with first stage empty");

	// input back-pressure only when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 &&
			valid_s5 && valid_s6 && valid_s7 && out_stall))
		else $error("input stalled with room in the pipeline");

	// an accepted item lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost at first stage");

	// output drains when it is taken and nothing follows
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s6) |=> !out_valid)
		else $error("item repeated at output");

endmodule
